### rtl/core/mec_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mec_pkg
// Shared types and constants of the escape-time counter.
// ----------------------------------------------------------------------------
package mec_pkg;

  localparam int COORD_BITS   = 12;
  localparam int FRAC_BITS    = 28;
  localparam int ITER_BITS    = 8;
  localparam int WORD_BITS    = 36;
  localparam int STEP_BITS    = 35;
  localparam int COLOR_BITS   = 4;
  localparam int STEP_LO_BITS = 18;
  localparam int STEP_HI_BITS = STEP_BITS - STEP_LO_BITS;

  // |z| components never exceed 2.0 when squared, so FRAC_BITS+3 signed bits do
  localparam int MUL_BITS  = FRAC_BITS + 3;
  localparam int PROD_BITS = 2 * MUL_BITS;
  // holds edge + coord * step before saturation
  localparam int ACC_BITS  = WORD_BITS + COORD_BITS + 2;

  localparam int DATA_BITS  = 64;
  localparam int PADDR_BITS = 6;
  localparam int REG_IDX_BITS = 3;

  localparam logic [REG_IDX_BITS-1:0] REG_LEFT_EDGE    = 3'd0;
  localparam logic [REG_IDX_BITS-1:0] REG_TOP_EDGE     = 3'd1;
  localparam logic [REG_IDX_BITS-1:0] REG_STEP_X       = 3'd2;
  localparam logic [REG_IDX_BITS-1:0] REG_STEP_Y       = 3'd3;
  localparam logic [REG_IDX_BITS-1:0] REG_MAX_ITER     = 3'd4;
  localparam logic [REG_IDX_BITS-1:0] REG_INSIDE_COLOR = 3'd5;

  localparam logic signed [WORD_BITS-1:0] RST_LEFT_EDGE = -WORD_BITS'(64'sd536870912);
  localparam logic signed [WORD_BITS-1:0] RST_TOP_EDGE  = WORD_BITS'(64'sd301989888);
  localparam logic [STEP_BITS-1:0]        RST_STEP      = STEP_BITS'(64'd196608);
  localparam logic [ITER_BITS-1:0]        RST_MAX_ITER  = ITER_BITS'(32);
  localparam logic [COLOR_BITS-1:0]       RST_INSIDE    = COLOR_BITS'(1);

  // escape bounds: a component beyond 2.0, or |z|^2 beyond 4.0
  localparam logic signed [WORD_BITS-1:0] ESC_HI = WORD_BITS'(64'sd2 <<< FRAC_BITS);
  localparam logic signed [WORD_BITS-1:0] ESC_LO = -ESC_HI;
  localparam logic signed [PROD_BITS-1:0] FOUR   = PROD_BITS'(64'sd4 <<< (2 * FRAC_BITS));

  localparam logic signed [ACC_BITS-1:0] SAT_HI =
    ACC_BITS'((64'sd1 <<< (WORD_BITS - 1)) - 64'sd1);
  localparam logic signed [ACC_BITS-1:0] SAT_LO = -SAT_HI - ACC_BITS'(1);

  typedef struct packed {
    logic signed [WORD_BITS-1:0] left_edge;
    logic signed [WORD_BITS-1:0] top_edge;
    logic [STEP_BITS-1:0]        step_x;
    logic [STEP_BITS-1:0]        step_y;
    logic [ITER_BITS-1:0]        max_iter;
    logic [COLOR_BITS-1:0]       inside_color;
  } mec_cfg_t;

  function automatic logic signed [WORD_BITS-1:0] sat_word(
    input logic signed [ACC_BITS-1:0] v
  );
    logic signed [ACC_BITS-1:0] r;
    r = v;
    if (v > SAT_HI) r = SAT_HI;
    if (v < SAT_LO) r = SAT_LO;
    return $signed(r[WORD_BITS-1:0]);
  endfunction

endpackage

### rtl/core/mec_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mec_cfg_regs
// Register file behind the APB-style port, one 64-bit slot per register.
// ----------------------------------------------------------------------------
module mec_cfg_regs
  import mec_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PADDR_BITS-1:0] paddr,
  input  logic [DATA_BITS-1:0]  pwdata,
  output logic [DATA_BITS-1:0]  prdata,
  output logic                  pready,
  output mec_cfg_t              cfg
);

  mec_cfg_t                cfg_r;
  logic                    wr_en;
  logic [REG_IDX_BITS-1:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = paddr[PADDR_BITS-1:PADDR_BITS-REG_IDX_BITS];
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.left_edge    <= RST_LEFT_EDGE;
      cfg_r.top_edge     <= RST_TOP_EDGE;
      cfg_r.step_x       <= RST_STEP;
      cfg_r.step_y       <= RST_STEP;
      cfg_r.max_iter     <= RST_MAX_ITER;
      cfg_r.inside_color <= RST_INSIDE;
    end else if (wr_en) begin
      unique case (idx)
        REG_LEFT_EDGE:    cfg_r.left_edge    <= $signed(pwdata[WORD_BITS-1:0]);
        REG_TOP_EDGE:     cfg_r.top_edge     <= $signed(pwdata[WORD_BITS-1:0]);
        REG_STEP_X:       cfg_r.step_x       <= pwdata[STEP_BITS-1:0];
        REG_STEP_Y:       cfg_r.step_y       <= pwdata[STEP_BITS-1:0];
        REG_MAX_ITER:     cfg_r.max_iter     <= pwdata[ITER_BITS-1:0];
        REG_INSIDE_COLOR: cfg_r.inside_color <= pwdata[COLOR_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_LEFT_EDGE:    prdata = DATA_BITS'(unsigned'(cfg_r.left_edge));
      REG_TOP_EDGE:     prdata = DATA_BITS'(unsigned'(cfg_r.top_edge));
      REG_STEP_X:       prdata = DATA_BITS'(cfg_r.step_x);
      REG_STEP_Y:       prdata = DATA_BITS'(cfg_r.step_y);
      REG_MAX_ITER:     prdata = DATA_BITS'(cfg_r.max_iter);
      REG_INSIDE_COLOR: prdata = DATA_BITS'(cfg_r.inside_color);
      default:          prdata = '0;
    endcase
  end

endmodule

### rtl/core/mec_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mec_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module mec_mul
  import mec_pkg::*;
(
  input  logic                        clk,
  input  logic signed [MUL_BITS-1:0]  a,
  input  logic signed [MUL_BITS-1:0]  b,
  output logic signed [PROD_BITS-1:0] prod_r
);

  logic signed [PROD_BITS-1:0] prod_nxt;

  assign prod_nxt = PROD_BITS'(a) * PROD_BITS'(b);

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

endmodule

### rtl/core/mec_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mec_ctrl
// Sequencer and datapath: forms c, then runs z = z^2 + c on the shared
// multiplier: square of re, square of im, cross product, update.
// ----------------------------------------------------------------------------
module mec_ctrl
  import mec_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst_n,
  input  mec_cfg_t                    cfg,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [COORD_BITS-1:0]       in_column,
  input  logic [COORD_BITS-1:0]       in_row,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [COORD_BITS-1:0]       out_pixel_column,
  output logic [COORD_BITS-1:0]       out_pixel_row,
  output logic [ITER_BITS-1:0]        out_iteration_count,
  output logic [COLOR_BITS-1:0]       out_color_index,
  output logic signed [MUL_BITS-1:0]  mul_a,
  output logic signed [MUL_BITS-1:0]  mul_b,
  input  logic signed [PROD_BITS-1:0] prod
);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_CX_LO  = 4'd1;
  localparam logic [3:0] ST_CX_HI  = 4'd2;
  localparam logic [3:0] ST_CY_LO  = 4'd3;
  localparam logic [3:0] ST_CY_HI  = 4'd4;
  localparam logic [3:0] ST_CY_END = 4'd5;
  localparam logic [3:0] ST_SQX    = 4'd6;
  localparam logic [3:0] ST_SQY    = 4'd7;
  localparam logic [3:0] ST_XY     = 4'd8;
  localparam logic [3:0] ST_UPD    = 4'd9;
  localparam logic [3:0] ST_DONE   = 4'd10;

  logic [3:0]                  state_r, state_nxt;
  logic [COORD_BITS-1:0]       col_r, row_r;
  logic signed [ACC_BITS-1:0]  acc_r;
  logic signed [WORD_BITS-1:0] cx_r, cy_r, zx_r, zy_r;
  logic signed [PROD_BITS-1:0] sq_r, re_r;
  logic [ITER_BITS-1:0]        count_r;
  logic                        out_valid_r;
  logic [COORD_BITS-1:0]       out_col_r, out_row_r;
  logic [ITER_BITS-1:0]        out_count_r;
  logic [COLOR_BITS-1:0]       out_color_r;

  logic signed [ACC_BITS-1:0]  prod_acc, prod_hi_acc;
  logic signed [PROD_BITS-1:0] re_sh, im_sh, sum_sq;
  logic signed [ACC_BITS-1:0]  re_sum, im_sum;
  logic [ITER_BITS-1:0]        count_inc;
  logic                        last_iter, z_big, out_free;

  assign in_ready            = (state_r == ST_IDLE);
  assign out_valid           = out_valid_r;
  assign out_pixel_column    = out_col_r;
  assign out_pixel_row       = out_row_r;
  assign out_iteration_count = out_count_r;
  assign out_color_index     = out_color_r;

  assign out_free  = !out_valid_r || out_ready;
  assign count_inc = count_r + ITER_BITS'(1);
  assign last_iter = (count_inc == cfg.max_iter);
  assign z_big     = (zx_r > ESC_HI) || (zx_r < ESC_LO) || (zy_r > ESC_HI) || (zy_r < ESC_LO);

  // c products stay well inside the accumulator, so truncation is safe
  assign prod_acc    = ACC_BITS'(prod);
  assign prod_hi_acc = prod_acc <<< STEP_LO_BITS;
  assign sum_sq      = sq_r + prod;
  assign re_sh       = re_r >>> FRAC_BITS;
  // 2*zx*zy scaled back: one fewer bit of shift
  assign im_sh       = prod >>> (FRAC_BITS - 1);
  assign re_sum      = ACC_BITS'(re_sh) + ACC_BITS'(cx_r);
  assign im_sum      = ACC_BITS'(im_sh) + ACC_BITS'(cy_r);

  // multiplier operand select
  always_comb begin
    unique case (state_r)
      ST_CX_LO: begin
        mul_a = $signed(MUL_BITS'(col_r));
        mul_b = $signed(MUL_BITS'(cfg.step_x[STEP_LO_BITS-1:0]));
      end
      ST_CX_HI: begin
        mul_a = $signed(MUL_BITS'(col_r));
        mul_b = $signed(MUL_BITS'(cfg.step_x[STEP_BITS-1:STEP_LO_BITS]));
      end
      ST_CY_LO: begin
        mul_a = $signed(MUL_BITS'(row_r));
        mul_b = $signed(MUL_BITS'(cfg.step_y[STEP_LO_BITS-1:0]));
      end
      ST_CY_HI: begin
        mul_a = $signed(MUL_BITS'(row_r));
        mul_b = $signed(MUL_BITS'(cfg.step_y[STEP_BITS-1:STEP_LO_BITS]));
      end
      ST_SQX: begin
        mul_a = $signed(zx_r[MUL_BITS-1:0]);
        mul_b = $signed(zx_r[MUL_BITS-1:0]);
      end
      ST_SQY: begin
        mul_a = $signed(zy_r[MUL_BITS-1:0]);
        mul_b = $signed(zy_r[MUL_BITS-1:0]);
      end
      ST_XY: begin
        mul_a = $signed(zx_r[MUL_BITS-1:0]);
        mul_b = $signed(zy_r[MUL_BITS-1:0]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = ST_CX_LO;
      ST_CX_LO:  state_nxt = ST_CX_HI;
      ST_CX_HI:  state_nxt = ST_CY_LO;
      ST_CY_LO:  state_nxt = ST_CY_HI;
      ST_CY_HI:  state_nxt = ST_CY_END;
      ST_CY_END: state_nxt = ST_SQX;
      ST_SQX:    state_nxt = z_big ? ST_DONE : ST_SQY;
      ST_SQY:    state_nxt = ST_XY;
      ST_XY:     state_nxt = (sum_sq > FOUR) ? ST_DONE : ST_UPD;
      ST_UPD:    state_nxt = last_iter ? ST_DONE : ST_SQX;
      ST_DONE:   if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        col_r   <= in_column;
        row_r   <= in_row;
        zx_r    <= '0;
        zy_r    <= '0;
        count_r <= '0;
      end
      ST_CX_HI:  acc_r <= ACC_BITS'(cfg.left_edge) + prod_acc;
      ST_CY_LO:  cx_r  <= sat_word(acc_r + prod_hi_acc);
      ST_CY_HI:  acc_r <= ACC_BITS'(cfg.top_edge) - prod_acc;
      ST_CY_END: cy_r  <= sat_word(acc_r - prod_hi_acc);
      ST_SQX:    if (z_big) count_r <= count_inc;
      ST_SQY:    sq_r <= prod;
      ST_XY: begin
        if (sum_sq > FOUR) count_r <= count_inc;
        re_r <= sq_r - prod;
      end
      ST_UPD: begin
        zx_r    <= sat_word(re_sum);
        zy_r    <= sat_word(im_sum);
        count_r <= count_inc;
      end
      ST_DONE: begin
        if (out_free) begin
          out_col_r   <= col_r;
          out_row_r   <= row_r;
          out_count_r <= count_r;
          out_color_r <= (count_r == cfg.max_iter) ? cfg.inside_color
                                                   : count_r[COLOR_BITS-1:0];
        end
      end
      default: ;
    endcase
  end

endmodule

### rtl/core/mandelbrot_escape_count_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mandelbrot_escape_count_top
// Escape-time counter: one request gives a pixel, one result its count.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : valid/ready request carrying a pixel column and row.
//   out_* : valid/ready result with the pixel echoed, the iteration count
//           and a colour index.
//   psel/penable/pwrite/paddr/pwdata : register writes at 8*index, only
//           while the block is idle.
// Sequence: c is formed on the shared multiplier, then each iteration takes
//   the squares of re and im, the cross product and the update, and the
//   result is handed over last; a limit of 0 wraps to 256 iterations.
// Flow: one pixel at a time; in_ready is high only while idle. The
//   single multiplier and its iteration loop set the pace.
// Stall: a result waits in the output register; a finished pixel waits in
//   its last state until that register is free, so nothing is dropped.
// Reset: rst_n (synchronous) returns the sequencer to idle, drops out_valid
//   and loads the default window (-2.0, 1.125), limit 32, inside colour 1.
// ----------------------------------------------------------------------------
module mandelbrot_escape_count_top
  import mec_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [COORD_BITS-1:0] in_column,
  input  logic [COORD_BITS-1:0] in_row,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [COORD_BITS-1:0] out_pixel_column,
  output logic [COORD_BITS-1:0] out_pixel_row,
  output logic [ITER_BITS-1:0]  out_iteration_count,
  output logic [COLOR_BITS-1:0] out_color_index,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PADDR_BITS-1:0] paddr,
  input  logic [DATA_BITS-1:0]  pwdata,
  output logic [DATA_BITS-1:0]  prdata,
  output logic                  pready
);

  mec_cfg_t                    cfg;
  logic signed [MUL_BITS-1:0]  mul_a, mul_b;
  logic signed [PROD_BITS-1:0] prod;

  mec_cfg_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  mec_mul u_mul (
    .clk    (clk),
    .a      (mul_a),
    .b      (mul_b),
    .prod_r (prod)
  );

  mec_ctrl u_ctrl (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg                 (cfg),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_column           (in_column),
    .in_row              (in_row),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_pixel_column    (out_pixel_column),
    .out_pixel_row       (out_pixel_row),
    .out_iteration_count (out_iteration_count),
    .out_color_index     (out_color_index),
    .mul_a               (mul_a),
    .mul_b               (mul_b),
    .prod                (prod)
  );

endmodule

### rtl/core/mec_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mec_checker
// Port-level checks of the escape-time counter, bound to the top level.
// ----------------------------------------------------------------------------
module mec_checker
  import mec_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [COORD_BITS-1:0] out_pixel_column,
  input logic [COORD_BITS-1:0] out_pixel_row,
  input logic [ITER_BITS-1:0]  out_iteration_count,
  input logic [COLOR_BITS-1:0] out_color_index,
  input logic                  pready
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pixel_column)
      && $stable(out_pixel_row) && $stable(out_iteration_count)
      && $stable(out_color_index))
    else $error("stalled result changed");

  // forming c alone keeps the block busy, so in_ready stays low after a request is taken
  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready ##1 !in_ready ##1 !in_ready ##1 !in_ready)
    else $error("request taken while busy");

  // a new result appears just as the sequencer returns to idle
  a_result_at_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> in_ready && !$past(in_ready))
    else $error("result without a finished request");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
    else $error("pready low");

endmodule

bind mandelbrot_escape_count_top mec_checker u_mec_checker (.*);
